/* design/epi_pkg.sv */
// ----------------------------------------------------------------------------
// epi_pkg: edge-preserving index shared definitions
// Field widths, accumulator and ratio formats, sequencer codes and the
// result record that travels from the divider to the output register.
// ----------------------------------------------------------------------------
package epi_pkg;

  localparam int PHASE_BITS  = 16;
  localparam int IMG_W_BITS  = 13;
  localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 13'd4096;
  localparam int MIN_WIDTH   = 2;

  localparam int ACC_BITS    = 48;
  localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

  localparam int FRAC_BITS   = 16;
  localparam int RATIO_BITS  = 32;
  localparam logic [RATIO_BITS-1:0] RATIO_MAX = {RATIO_BITS{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRAD,
    ST_LOAD,
    ST_DIV
  } epi_state_t;

  typedef enum logic [1:0] {
    STEP_F_RIGHT,
    STEP_F_DOWN,
    STEP_O_RIGHT,
    STEP_O_DOWN
  } epi_step_t;

  typedef struct packed {
    logic [RATIO_BITS-1:0] index_ratio;
    logic                  zero_denominator;
    logic [ACC_BITS-1:0]   filtered_gradient_sum;
    logic [ACC_BITS-1:0]   original_gradient_sum;
  } epi_result_t;

endpackage

/* design/epi_ifs.sv */
// ----------------------------------------------------------------------------
// epi_ifs: channel interfaces
// Pixel request, result request and configuration write channels, each a
// valid/ready handshake with its payload.
// ----------------------------------------------------------------------------
interface epi_pixel_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [epi_pkg::PHASE_BITS-1:0] filtered_phase;
  logic signed [epi_pkg::PHASE_BITS-1:0] original_phase;
  logic                                  last_pixel;

  modport source (output valid, filtered_phase, original_phase, last_pixel, input ready);
  modport sink   (input valid, filtered_phase, original_phase, last_pixel, output ready);
endinterface

interface epi_result_if;
  logic                                valid;
  logic                                ready;
  logic [epi_pkg::RATIO_BITS-1:0]      index_ratio;
  logic                                zero_denominator;
  logic [epi_pkg::ACC_BITS-1:0]        filtered_gradient_sum;
  logic [epi_pkg::ACC_BITS-1:0]        original_gradient_sum;

  modport source (output valid, index_ratio, zero_denominator, filtered_gradient_sum,
                  original_gradient_sum, input ready);
  modport sink   (input valid, index_ratio, zero_denominator, filtered_gradient_sum,
                  original_gradient_sum, output ready);
endinterface

interface epi_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [epi_pkg::IMG_W_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* design/epi_line_store.sv */
// ----------------------------------------------------------------------------
// epi_line_store: previous-row memory
// One write port and two registered read ports, read-before-write.
// ----------------------------------------------------------------------------
module epi_line_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [DW-1:0] rd_data_a,
  output logic [DW-1:0] rd_data_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

/* design/epi_grad_unit.sv */
// ----------------------------------------------------------------------------
// epi_grad_unit: wrapped gradient and saturating accumulate
// Absolute wrapped difference of two phases added to an accumulator that
// sticks at its maximum.
// ----------------------------------------------------------------------------
module epi_grad_unit (
  input  logic [epi_pkg::PHASE_BITS-1:0] to_phase,
  input  logic [epi_pkg::PHASE_BITS-1:0] from_phase,
  input  logic [epi_pkg::ACC_BITS-1:0]   acc_in,
  output logic [epi_pkg::ACC_BITS-1:0]   acc_sum
);
  import epi_pkg::*;

  logic [PHASE_BITS-1:0] diff;
  logic [PHASE_BITS-1:0] mag;
  logic [ACC_BITS:0]     wide_sum;

  always_comb begin
    diff     = to_phase - from_phase;
    // negate when the wrapped difference reads as negative; -pi maps to +pi
    mag      = diff[PHASE_BITS-1] ? (~diff + 1'b1) : diff;
    wide_sum = {1'b0, acc_in} + (ACC_BITS+1)'(mag);
    acc_sum  = wide_sum[ACC_BITS] ? ACC_MAX : wide_sum[ACC_BITS-1:0];
  end

endmodule

/* design/epi_divider.sv */
// ----------------------------------------------------------------------------
// epi_divider: Q16.16 ratio divider
// Restoring division, one quotient bit a cycle, with early exit on a zero
// denominator or a quotient that saturates.
// ----------------------------------------------------------------------------
module epi_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [epi_pkg::ACC_BITS-1:0] fsum,
  input  logic [epi_pkg::ACC_BITS-1:0] osum,
  output logic                         done,
  output epi_pkg::epi_result_t         result
);
  import epi_pkg::*;

  localparam int CNT_W = $clog2(RATIO_BITS + 1);

  logic [ACC_BITS-1:0]   fs_r, os_r, rem_r;
  logic [RATIO_BITS-1:0] nlow_r, quo_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  sat_r, zero_r, done_r;

  logic                  zero_c, sat_c;
  logic [ACC_BITS:0]     shifted, diff;
  logic                  ge;

  always_comb begin
    zero_c  = (osum == '0);
    sat_c   = !zero_c &&
              ({{FRAC_BITS{1'b0}}, fsum} >= {osum, {FRAC_BITS{1'b0}}});
    shifted = {rem_r, nlow_r[RATIO_BITS-1]};
    diff    = shifted - {1'b0, os_r};
    ge      = (shifted >= {1'b0, os_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= (zero_c || sat_c) ? '0 : CNT_W'(RATIO_BITS);
      done_r <= zero_c || sat_c;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      fs_r   <= fsum;
      os_r   <= osum;
      zero_r <= zero_c;
      sat_r  <= sat_c;
      rem_r  <= ACC_BITS'(fsum >> (RATIO_BITS - FRAC_BITS));
      nlow_r <= {fsum[RATIO_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      quo_r  <= '0;
    end else if (cnt_r != '0) begin
      rem_r  <= ge ? diff[ACC_BITS-1:0] : shifted[ACC_BITS-1:0];
      quo_r  <= {quo_r[RATIO_BITS-2:0], ge};
      nlow_r <= {nlow_r[RATIO_BITS-2:0], 1'b0};
    end
  end

  assign done = done_r;

  always_comb begin
    result.index_ratio           = sat_r ? RATIO_MAX : (zero_r ? '0 : quo_r);
    result.zero_denominator      = zero_r;
    result.filtered_gradient_sum = fs_r;
    result.original_gradient_sum = os_r;
  end

endmodule

/* design/phase_edge_preserving_index_top.sv */
// ----------------------------------------------------------------------------
// phase_edge_preserving_index_top: edge-preserving index of wrapped phase
// Accumulates absolute wrapped right and down gradients of a filtered and an
// original phase image and reports their ratio at the end of each image.
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake     | payload
//   ----------+-----------+---------------+------------------------------------
//   in_ch     | sink      | valid / ready | filtered_phase, original_phase,
//             |           |               | last_pixel
//   out_ch    | source    | valid / ready | index_ratio, zero_denominator,
//             |           |               | filtered_gradient_sum,
//             |           |               | original_gradient_sum
//   cfg_ch    | sink      | valid / ready | data (image_width), always ready
//
// A pixel in the first row or the last column is only accepted. Any other
// pixel is accepted and then makes four passes (ST_GRAD) through the one
// shared wrapped-gradient/saturating-add unit. The last pixel of an image
// then adds a load state and the divider (32 quotient bits, one bit a cycle,
// exiting early on a zero denominator or a saturated ratio), before the
// result request enters the output register.
// Reset is synchronous and active low; the line store is not cleared.
// A stalled result request holds in the output register while the next image
// streams in; only a second finished result waits for it to drain.
// ----------------------------------------------------------------------------
module phase_edge_preserving_index_top #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic clk,
  input  logic rst_n,
  epi_pixel_if.sink    in_ch,
  epi_result_if.source out_ch,
  epi_cfg_if.sink      cfg_ch
);
  import epi_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int LW = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;
  localparam int DW = 2 * PHASE_BITS;

  // Sequencer and image state
  epi_state_t state_r, state_nxt;
  epi_step_t  step_r, step_nxt;

  logic [IMG_W_BITS-1:0] width_r;
  logic [CW-1:0]         col_r;
  logic                  frd_r;         // first row done
  logic [ACC_BITS-1:0]   facc_r, oacc_r;

  // Latched pixel
  logic [PHASE_BITS-1:0] cur_f_r, cur_o_r;
  logic                  last_r;

  // Output register
  logic        out_valid_r;
  epi_result_t out_q_r;

  // Sequencer outputs
  logic in_ready_c, grad_en_c, div_start_c, out_load_c;

  logic          in_acc;
  logic [LW-1:0] weff;
  logic [LW-1:0] wext;
  logic [CW:0]   col_inc;
  logic          row_cont, contribute;
  logic          out_free;

  logic [DW-1:0] rd_origin, rd_right;
  logic [PHASE_BITS-1:0] g_to, g_from;
  logic [ACC_BITS-1:0]   g_acc, g_sum;
  logic                  g_filt;

  logic        div_done;
  epi_result_t div_res;

  assign in_acc   = in_ch.valid && in_ready_c;
  assign out_free = !out_valid_r || out_ch.ready;

  // Clamp the programmed width into the supported range
  always_comb begin
    wext = LW'(width_r);
    if (wext < LW'(MIN_WIDTH)) begin
      weff = LW'(MIN_WIDTH);
    end else if (wext > LW'(MAX_WIDTH)) begin
      weff = LW'(MAX_WIDTH);
    end else begin
      weff = wext;
    end
    col_inc    = {1'b0, col_r} + 1'b1;
    // a column at or beyond the last one ends the row
    row_cont   = (LW'(col_inc) < weff);
    contribute = row_cont && frd_r;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (contribute) begin
            state_nxt = ST_GRAD;
          end else if (in_ch.last_pixel) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      ST_GRAD: begin
        if (step_r == STEP_O_DOWN) begin
          state_nxt = last_r ? ST_LOAD : ST_IDLE;
        end
      end
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_done && out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready_c  = 1'b0;
    grad_en_c   = 1'b0;
    div_start_c = 1'b0;
    out_load_c  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready_c  = 1'b1;
      ST_GRAD: grad_en_c   = 1'b1;
      ST_LOAD: div_start_c = 1'b1;
      ST_DIV:  out_load_c  = div_done && out_free;
      default: in_ready_c  = 1'b0;
    endcase
  end

  // Step through the four gradients of one origin pixel
  always_comb begin
    step_nxt = step_r;
    if (in_acc) begin
      step_nxt = STEP_F_RIGHT;
    end else if (grad_en_c) begin
      case (step_r)
        STEP_F_RIGHT: step_nxt = STEP_F_DOWN;
        STEP_F_DOWN:  step_nxt = STEP_O_RIGHT;
        STEP_O_RIGHT: step_nxt = STEP_O_DOWN;
        STEP_O_DOWN:  step_nxt = STEP_F_RIGHT;
        default:      step_nxt = STEP_F_RIGHT;
      endcase
    end
  end

  // Operand selection for the shared gradient unit. Store words hold the
  // filtered phase in the upper half and the original phase in the lower.
  always_comb begin
    g_filt = 1'b1;
    g_to   = rd_right[DW-1:PHASE_BITS];
    g_from = rd_origin[DW-1:PHASE_BITS];
    case (step_r)
      STEP_F_RIGHT: begin
        g_to = rd_right[DW-1:PHASE_BITS];
      end
      STEP_F_DOWN: begin
        g_to = cur_f_r;
      end
      STEP_O_RIGHT: begin
        g_filt = 1'b0;
        g_to   = rd_right[PHASE_BITS-1:0];
        g_from = rd_origin[PHASE_BITS-1:0];
      end
      STEP_O_DOWN: begin
        g_filt = 1'b0;
        g_to   = cur_o_r;
        g_from = rd_origin[PHASE_BITS-1:0];
      end
      default: g_filt = 1'b1;
    endcase
    g_acc = g_filt ? facc_r : oacc_r;
  end

  epi_grad_unit u_grad (
    .to_phase   (g_to),
    .from_phase (g_from),
    .acc_in     (g_acc),
    .acc_sum    (g_sum)
  );

  // Read origin and right neighbour and overwrite the origin in the same cycle
  epi_line_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW),
    .DW    (DW)
  ) u_store (
    .clk       (clk),
    .wr_en     (in_acc),
    .wr_addr   (col_r),
    .wr_data   ({in_ch.filtered_phase, in_ch.original_phase}),
    .rd_en     (in_acc && contribute),
    .rd_addr_a (col_r),
    .rd_addr_b (col_inc[CW-1:0]),
    .rd_data_a (rd_origin),
    .rd_data_b (rd_right)
  );

  epi_divider u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start_c),
    .fsum   (facc_r),
    .osum   (oacc_r),
    .done   (div_done),
    .result (div_res)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= STEP_F_RIGHT;
      width_r     <= IMG_W_RESET;
      col_r       <= '0;
      frd_r       <= 1'b0;
      facc_r      <= '0;
      oacc_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;

      if (cfg_ch.valid) begin
        width_r <= cfg_ch.data;
      end

      if (in_acc) begin
        if (row_cont) begin
          col_r <= col_inc[CW-1:0];
        end else begin
          col_r <= '0;
          frd_r <= 1'b1;
        end
      end

      if (grad_en_c) begin
        if (g_filt) begin
          facc_r <= g_sum;
        end else begin
          oacc_r <= g_sum;
        end
      end

      // divider takes the sums on this edge; drop the image state
      if (div_start_c) begin
        col_r  <= '0;
        frd_r  <= 1'b0;
        facc_r <= '0;
        oacc_r <= '0;
      end

      if (out_load_c) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_f_r <= in_ch.filtered_phase;
      cur_o_r <= in_ch.original_phase;
      last_r  <= in_ch.last_pixel;
    end
    if (out_load_c) begin
      out_q_r <= div_res;
    end
  end

  assign in_ch.ready                  = in_ready_c;
  assign cfg_ch.ready                 = 1'b1;
  assign out_ch.valid                 = out_valid_r;
  assign out_ch.index_ratio           = out_q_r.index_ratio;
  assign out_ch.zero_denominator      = out_q_r.zero_denominator;
  assign out_ch.filtered_gradient_sum = out_q_r.filtered_gradient_sum;
  assign out_ch.original_gradient_sum = out_q_r.original_gradient_sum;

endmodule

/* design/epi_checker.sv */
// ----------------------------------------------------------------------------
// epi_checker: port-level checks
// Result request handshake and result consistency, seen from the ports.
// ----------------------------------------------------------------------------
module epi_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         in_last,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [epi_pkg::RATIO_BITS-1:0] out_ratio,
  input logic                         out_zero,
  input logic [epi_pkg::ACC_BITS-1:0] out_fsum,
  input logic [epi_pkg::ACC_BITS-1:0] out_osum
);
  import epi_pkg::*;

  // stalled result request stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      $stable(out_ratio) && $stable(out_zero) && $stable(out_fsum) && $stable(out_osum))
    else $error("result payload changed while stalled");

  // zero flag matches an empty denominator and forces a zero ratio
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_zero == (out_osum == '0)) && (!out_zero || out_ratio == '0))
    else $error("zero denominator flag inconsistent");

  // the divider runs after a last pixel, so the input side must stall
  a_last_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> !in_ready)
    else $error("pixel accepted straight after last pixel");

endmodule

bind phase_edge_preserving_index_top epi_checker u_epi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_pixel),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_ratio (out_ch.index_ratio),
  .out_zero  (out_ch.zero_denominator),
  .out_fsum  (out_ch.filtered_gradient_sum),
  .out_osum  (out_ch.original_gradient_sum)
);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: edge-preserving index, wrapped phase
// Streams raster-order pixel requests into the block and predicts each
// end-of-image ratio request from a line-store model of the gradient sums.
// Every ratio request is checked field by field against the oldest
// prediction. Covers the width extremes and clamping, zero denominators,
// ratio saturation, width changes mid-image, early last pixels, random
// idling on both sides and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W          = 4096;
  localparam int DRAIN_CYCLES   = 40;     // gradient passes of a pixel, load, 32 divider bits, output
  localparam int WATCHDOG_LIMIT = 20000;  // well above the long output hold-off
  localparam int HOLD_OFF_LEN   = 3000;
  localparam int MAX_REPORTS    = 30;

  typedef enum int {
    PH_NOISE,
    PH_SMOOTH,
    PH_EXTREME,
    PH_FLAT
  } phase_mode_t;

  logic clk;
  logic rst_n;

  epi_pixel_if  pix_if ();
  epi_result_if res_if ();
  epi_cfg_if    cfg_if ();

  phase_edge_preserving_index_top #(
    .MAX_WIDTH (MAX_W)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (pix_if),
    .out_ch (res_if),
    .cfg_ch (cfg_if)
  );

  // --------------------------------------------------------------------------
  // Gradient model: its own copy of the width register, line store and sums
  // --------------------------------------------------------------------------
  logic [epi_pkg::IMG_W_BITS-1:0] width_reg;
  logic [15:0]                    line_filt [MAX_W];
  logic [15:0]                    line_orig [MAX_W];
  int unsigned                    col_pos;
  bit                             row_done;
  int unsigned                    store_hi;   // store entries [0, store_hi) written
  logic [epi_pkg::ACC_BITS-1:0]   acc_filt;
  logic [epi_pkg::ACC_BITS-1:0]   acc_orig;

  epi_pkg::epi_result_t pending_ratios [$];

  int mismatch_count;
  int pixels_sent;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_left;

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int unsigned effective_width();
    if (width_reg < epi_pkg::MIN_WIDTH) return epi_pkg::MIN_WIDTH;
    if (width_reg > MAX_W) return MAX_W;
    return width_reg;
  endfunction

  // Magnitude of the wrapped difference: read the 16-bit difference as a
  // signed value in [-pi, pi) and take its absolute value (pi stays pi).
  function automatic logic [17:0] wrap_mag(input logic [15:0] to_ph, from_ph);
    logic [15:0] d;
    d = to_ph - from_ph;
    if (d[15]) return 18'h10000 - {2'b00, d};
    return {2'b00, d};
  endfunction

  function automatic logic [47:0] sat_add(input logic [47:0] acc, input logic [17:0] v);
    logic [48:0] s;
    s = {1'b0, acc} + 49'(v);
    return s[48] ? epi_pkg::ACC_MAX : s[47:0];
  endfunction

  // Advance the model by one accepted pixel; queue a ratio on the last pixel.
  function automatic void accumulate_gradients(input logic [15:0] f, o, input logic last);
    int unsigned          w;
    int unsigned          c;
    logic [63:0]          quotient;
    epi_pkg::epi_result_t res;
    w = effective_width();
    c = col_pos;
    if (c + 1 < w) begin
      // The current pixel is the lower neighbour of store[c]; store[c+1] is
      // the right neighbour.
      if (row_done) begin
        acc_filt = sat_add(acc_filt, wrap_mag(line_filt[c + 1], line_filt[c])
                                     + wrap_mag(f, line_filt[c]));
        acc_orig = sat_add(acc_orig, wrap_mag(line_orig[c + 1], line_orig[c])
                                     + wrap_mag(o, line_orig[c]));
      end
      col_pos = c + 1;
    end else begin
      // Last column, or beyond it after a narrowing: end the row.
      col_pos  = 0;
      row_done = 1'b1;
    end
    line_filt[c] = f;
    line_orig[c] = o;
    if (c + 1 > store_hi) store_hi = c + 1;
    if (last) begin
      res.filtered_gradient_sum = acc_filt;
      res.original_gradient_sum = acc_orig;
      if (acc_orig == '0) begin
        res.index_ratio      = '0;
        res.zero_denominator = 1'b1;
      end else begin
        quotient = {acc_filt, 16'h0000} / {16'h0000, acc_orig};
        res.index_ratio      = (quotient > 64'hFFFF_FFFF) ? epi_pkg::RATIO_MAX
                                                          : quotient[31:0];
        res.zero_denominator = 1'b0;
      end
      pending_ratios.push_back(res);
      col_pos  = 0;
      row_done = 1'b0;
      acc_filt = '0;
      acc_orig = '0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Ratio checker: compare every accepted result request with the oldest
  // prediction
  // --------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [47:0] want, got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t ns: %s expected %h, got %h", $time, name, want, got);
    end
  endfunction

  initial begin
    epi_pkg::epi_result_t want;
    forever begin
      @(posedge clk);
      if (res_if.valid && res_if.ready) begin
        if (pending_ratios.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("%0t ns: result request expected none, got ratio %h", $time,
                     res_if.index_ratio);
        end else begin
          want = pending_ratios.pop_front();
          compare_field("index_ratio", want.index_ratio, res_if.index_ratio);
          compare_field("zero_denominator", want.zero_denominator,
                        res_if.zero_denominator);
          compare_field("filtered_gradient_sum", want.filtered_gradient_sum,
                        res_if.filtered_gradient_sum);
          compare_field("original_gradient_sum", want.original_gradient_sum,
                        res_if.original_gradient_sum);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random stalls, plus a counted hold-off when asked for
  // --------------------------------------------------------------------------
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        res_if.ready <= 1'b0;
        hold_off_left--;
      end else begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run if nothing moves on any channel for too long
  // --------------------------------------------------------------------------
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; all of them start and end at a falling edge
  // --------------------------------------------------------------------------

  // Offer one pixel request, with random idle cycles first, and hold it until
  // accepted. Valid stays high on return so back-to-back pixels need no gap.
  task automatic send_pixel(input logic [15:0] f, o, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk);
    end
    pix_if.valid          <= 1'b1;
    pix_if.filtered_phase <= f;
    pix_if.original_phase <= o;
    pix_if.last_pixel     <= last;
    do begin
      @(posedge clk);
    end while (!(pix_if.valid && pix_if.ready));
    accumulate_gradients(f, o, last);
    pixels_sent++;
    @(negedge clk);
  endtask

  // Drop the pixel valid, wait for every predicted ratio, then let the block
  // finish any pixel still in its gradient passes.
  task automatic settle_block();
    pix_if.valid <= 1'b0;
    while (pending_ratios.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_width(input logic [epi_pkg::IMG_W_BITS-1:0] value);
    settle_block();
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= value;
    do begin
      @(posedge clk);
    end while (!(cfg_if.valid && cfg_if.ready));
    width_reg = value;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Pick a width that never makes the block read a store entry not yet
  // written: once a row is done, the next row reads up to column width-1.
  function automatic logic [epi_pkg::IMG_W_BITS-1:0] pick_width();
    int unsigned top;
    top = 64;
    if (row_done && store_hi < top) top = store_hi;
    case ($urandom_range(9))
      0:       return epi_pkg::IMG_W_BITS'($urandom_range(1));  // behaves as 2
      1, 2:    return epi_pkg::IMG_W_BITS'($urandom_range(2, top));
      default: return epi_pkg::IMG_W_BITS'($urandom_range(2, (top < 12) ? top : 12));
    endcase
  endfunction

  function automatic logic [15:0] next_phase(input phase_mode_t mode, input logic [15:0] prev);
    case (mode)
      PH_SMOOTH:  return prev + 16'($urandom_range(64)) - 16'd32;
      PH_FLAT:    return prev;
      PH_EXTREME: begin
        case ($urandom_range(3))
          0:       return 16'h8000;
          1:       return 16'h7FFF;
          2:       return 16'h0000;
          default: return 16'hFFFF;
        endcase
      end
      default:    return 16'($urandom);
    endcase
  endfunction

  // Stream n_pix pixels, marking last_at as the final pixel; a width write
  // lands just before pixel change_at when that is in range.
  task automatic send_image(input int n_pix, input int last_at, input phase_mode_t f_mode,
                            input phase_mode_t o_mode, input int change_at);
    logic [15:0] f;
    logic [15:0] o;
    f = 16'($urandom);
    o = 16'($urandom);
    for (int i = 0; i < n_pix; i++) begin
      if (i == change_at) write_width(pick_width());
      f = next_phase(f_mode, f);
      o = next_phase(o_mode, o);
      send_pixel(f, o, i == last_at);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // 2x2 image with both phase extremes; differences of exactly pi appear in
  // both images, and -pi to just below pi wraps to a step of one.
  task automatic test_minimum_width();
    write_width(2);
    send_pixel(16'h8000, 16'h0000, 1'b0);
    send_pixel(16'h7FFF, 16'h8000, 1'b0);
    send_pixel(16'h0000, 16'h7FFF, 1'b0);
    send_pixel(16'hFFFF, 16'h8000, 1'b1);
  endtask

  // Last pixel inside the first row (nothing summed), then a flat original.
  task automatic test_zero_denominator();
    send_image(1, 0, PH_NOISE, PH_NOISE, -1);
    send_image(4, 3, PH_NOISE, PH_FLAT, -1);
  endtask

  // Original sum of one against a filtered sum of one full turn: ratio clips.
  task automatic test_saturated_ratio();
    send_pixel(16'h0000, 16'h0000, 1'b0);
    send_pixel(16'h8000, 16'h0001, 1'b0);
    send_pixel(16'h8000, 16'h0000, 1'b0);
    send_pixel(16'h0000, 16'h0000, 1'b1);
  endtask

  // Widths 0 and 1 behave as 2; the second image ends mid-row.
  task automatic test_width_clamp();
    write_width('0);
    send_image(4, 3, PH_EXTREME, PH_NOISE, -1);
    write_width(1);
    send_image(3, 2, PH_NOISE, PH_NOISE, -1);
  endtask

  // Narrow from 4 to 2 at row 1, column 2: that pixel ends its row, and the
  // rest of the image streams at the new width.
  task automatic test_mid_image_width();
    logic [15:0] f;
    logic [15:0] o;
    write_width(4);
    for (int i = 0; i < 10; i++) begin
      if (i == 6) write_width(2);
      f = 16'($urandom);
      o = 16'($urandom);
      send_pixel(f, o, i == 9);
    end
  endtask

  // Widest rows: an all-ones register clamps to the line store depth. Short
  // images stay inside the first row and close with an empty denominator.
  task automatic test_widest_rows();
    write_width({epi_pkg::IMG_W_BITS{1'b1}});
    send_image(6, 5, PH_SMOOTH, PH_NOISE, -1);
    write_width(MAX_W);
    send_image(3, 2, PH_NOISE, PH_SMOOTH, -1);
  endtask

  // Mostly complete images of random small sizes and content; a few end
  // early, some rewrite the width between images or mid-image.
  task automatic run_random_phase(input int n_items, input int send_pct, input int recv_pct);
    int start_count;
    int n_pix;
    int last_at;
    int change_at;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    start_count    = pixels_sent;
    while (pixels_sent - start_count < n_items) begin
      if ($urandom_range(99) < 20) write_width(pick_width());
      n_pix     = $urandom_range(2, 5) * effective_width();
      last_at   = ($urandom_range(99) < 10) ? $urandom_range(n_pix - 1) : n_pix - 1;
      change_at = ($urandom_range(99) < 5) ? $urandom_range(1, n_pix - 1) : -1;
      send_image(n_pix, last_at, phase_mode_t'($urandom_range(3)),
                 phase_mode_t'($urandom_range(3)), change_at);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(440, 0, 0);
    run_random_phase(440, 78, 0);
    run_random_phase(440, 0, 78);
    run_random_phase(440, 14, 14);
  endtask

  // Hold the receiver off for a long stretch while tiny images keep coming,
  // so finished results back up and the pixel input stalls; then pause the
  // sender until every result has drained.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_width(2);
    hold_off_left = HOLD_OFF_LEN;
    repeat (16) send_image(4, 3, PH_NOISE, PH_SMOOTH, -1);
    settle_block();
    repeat (4) send_image(6, 5, PH_SMOOTH, PH_NOISE, -1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    // Drive every input to a known value and initialise the model.
    rst_n                 = 1'b0;
    pix_if.valid          = 1'b0;
    pix_if.filtered_phase = '0;
    pix_if.original_phase = '0;
    pix_if.last_pixel     = 1'b0;
    cfg_if.valid          = 1'b0;
    cfg_if.data           = '0;
    width_reg             = epi_pkg::IMG_W_RESET;
    col_pos               = 0;
    row_done              = 1'b0;
    store_hi              = 0;
    acc_filt              = '0;
    acc_orig              = '0;
    mismatch_count        = 0;
    pixels_sent           = 0;
    send_idle_pct         = 0;
    recv_stall_pct        = 0;
    hold_off_left         = 0;
    for (int i = 0; i < MAX_W; i++) begin
      line_filt[i] = '0;
      line_orig[i] = '0;
    end

    // Hold reset low, then release it at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_minimum_width();
    test_zero_denominator();
    test_saturated_ratio();
    test_width_clamp();
    test_mid_image_width();
    test_widest_rows();
    test_random_traffic();
    test_output_backpressure();

    // Drain every outstanding ratio, then allow the pipeline to go quiet.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle_block();

    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
